// ===== rtl/sdkh_pkg.sv =====
// ----------------------------------------------------------------------------
// sdkh_pkg
// Shared types, constants and helper functions of the seeded dual key hash.
// ----------------------------------------------------------------------------
package sdkh_pkg;

  localparam int unsigned KeyWidth         = 32;
  localparam int unsigned CfgIdxWidth      = 3;
  localparam int unsigned CfgDataWidth     = 32;

  localparam logic [KeyWidth-1:0] CrcPoly  = 32'h82F6_3B78;
  localparam int unsigned CrcStepsPerStage = 8;
  localparam int unsigned CrcStagesPerWord = KeyWidth / CrcStepsPerStage;
  // one prepare stage, then two CRC words of bit steps
  localparam int unsigned NumPipe          = 1 + 2 * CrcStagesPerWord;

  localparam int unsigned RotA = 15;
  localparam int unsigned RotB = 7;
  localparam int unsigned RotC = 11;
  localparam int unsigned RotD = 20;

  typedef enum logic [1:0] {
    ModeCrcRot   = 2'd0,
    ModeRotXor   = 2'd1,
    ModeAddXor   = 2'd2,
    ModePlainXor = 2'd3
  } hash_mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegHashMode  = 3'd0,
    RegSeedOne   = 3'd1,
    RegSeedTwo   = 3'd2,
    RegSeedThree = 3'd3,
    RegSeedFour  = 3'd4
  } cfg_reg_e;

  function automatic logic [KeyWidth-1:0] rotl(logic [KeyWidth-1:0] v, int unsigned n);
    return (v << n) | (v >> (KeyWidth - n));
  endfunction

  function automatic logic [KeyWidth-1:0] rotr(logic [KeyWidth-1:0] v, int unsigned n);
    return (v >> n) | (v << (KeyWidth - n));
  endfunction

  // one slice of reflected CRC32C bit steps
  function automatic logic [KeyWidth-1:0] crc_slice(logic [KeyWidth-1:0] c);
    logic [KeyWidth-1:0] r;
    r = c;
    for (int i = 0; i < CrcStepsPerStage; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/seeded_dual_key_hash.sv =====
// ----------------------------------------------------------------------------
// seeded_dual_key_hash
// Hashes a 32-bit key into two seeded 32-bit vertices and a collision flag.
// ----------------------------------------------------------------------------
// Usage:
//   Keys enter on the in_valid_i / in_ready_o request channel, results leave
//   on out_valid_o / out_ready_i with vertex_low_o, vertex_high_o and
//   status_o. Status 1 marks a collision; both vertices then read zero.
//   Mode and seeds are set through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no request is in flight; unknown indexes are dropped.
//   From acceptance until its result is shown, a request passes one prepare
//   stage, eight stages of eight CRC bit steps each (two chained CRC words
//   in crc rotate mode) and the output register. Every mode takes the same
//   path, so results keep order.
//   Throughput is one request per cycle. When the receiver stalls, the output
//   register holds and empty stages behind it keep filling; input is refused
//   only once every stage holds a request.
//   Reset clears all valid bits and sets the mode and all seeds to zero.
// ----------------------------------------------------------------------------
module seeded_dual_key_hash (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sdkh_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [sdkh_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sdkh_pkg::KeyWidth-1:0]     key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sdkh_pkg::KeyWidth-1:0]     vertex_low_o,
  output logic [sdkh_pkg::KeyWidth-1:0]     vertex_high_o,
  output logic                              status_o
);
  import sdkh_pkg::*;

  hash_mode_e          hash_mode_q;
  logic [KeyWidth-1:0] seed_one_q, seed_two_q, seed_three_q, seed_four_q;

  logic [NumPipe-1:0]  vld_q, vld_d;
  logic [KeyWidth-1:0] key_q [NumPipe];
  logic [KeyWidth-1:0] key_d [NumPipe];
  logic [KeyWidth-1:0] v1_q  [NumPipe];
  logic [KeyWidth-1:0] v1_d  [NumPipe];
  logic [KeyWidth-1:0] v2_q  [NumPipe];
  logic [KeyWidth-1:0] v2_d  [NumPipe];
  logic [NumPipe:0]    en;

  logic                out_vld_q;
  logic [KeyWidth-1:0] vlow_q, vlow_d, vhigh_q, vhigh_d;
  logic                status_q, status_d;
  logic [KeyWidth-1:0] src2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mode_q  <= ModeCrcRot;
      seed_one_q   <= '0;
      seed_two_q   <= '0;
      seed_three_q <= '0;
      seed_four_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHashMode:  hash_mode_q  <= hash_mode_e'(cfg_data_i[1:0]);
        RegSeedOne:   seed_one_q   <= cfg_data_i;
        RegSeedTwo:   seed_two_q   <= cfg_data_i;
        RegSeedThree: seed_three_q <= cfg_data_i;
        RegSeedFour:  seed_four_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance enables, from the output back to the input
  always_comb begin
    en[NumPipe] = !out_vld_q || out_ready_i;
    for (int k = NumPipe - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    vld_d[0] = in_valid_i;
    key_d[0] = key_i;
    case (hash_mode_q)
      ModeCrcRot: begin
        v1_d[0] = seed_one_q ^ key_i;
        v2_d[0] = seed_two_q ^ rotl(key_i, RotA);
      end
      ModeRotXor: begin
        v1_d[0] = rotl(key_i ^ seed_one_q, RotA) ^ rotr(key_i - seed_three_q, RotC);
        v2_d[0] = rotl(key_i + seed_two_q, RotB) ^ rotr(key_i ^ seed_four_q, RotD);
      end
      ModeAddXor: begin
        v1_d[0] = key_i + seed_one_q;
        v2_d[0] = (key_i + seed_one_q) ^ (key_i - seed_two_q) ^ seed_three_q;
      end
      default: begin
        v1_d[0] = key_i ^ seed_one_q;
        v2_d[0] = key_i ^ seed_two_q;
      end
    endcase

    src2 = '0;
    for (int k = 1; k < NumPipe; k++) begin
      vld_d[k] = vld_q[k-1];
      key_d[k] = key_q[k-1];
      v1_d[k]  = v1_q[k-1];
      src2     = v2_q[k-1];
      if (hash_mode_q == ModeCrcRot) begin
        if (k == CrcStagesPerWord + 1) begin
          src2 = src2 ^ seed_three_q ^ key_q[k-1];
        end
        if (k <= CrcStagesPerWord) begin
          v1_d[k] = crc_slice(v1_q[k-1]);
        end
        src2 = crc_slice(src2);
      end
      v2_d[k] = src2;
    end
  end

  always_comb begin
    status_d = (v1_q[NumPipe-1] == v2_q[NumPipe-1]);
    vlow_d   = status_d ? '0 : v1_q[NumPipe-1];
    vhigh_d  = status_d ? '0 : v2_q[NumPipe-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      for (int k = 0; k < NumPipe; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
      if (en[NumPipe]) begin
        out_vld_q <= vld_q[NumPipe-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumPipe; k++) begin
      if (en[k] && vld_d[k]) begin
        key_q[k] <= key_d[k];
        v1_q[k]  <= v1_d[k];
        v2_q[k]  <= v2_d[k];
      end
    end
    if (en[NumPipe] && vld_q[NumPipe-1]) begin
      vlow_q   <= vlow_d;
      vhigh_q  <= vhigh_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign vertex_low_o  = vlow_q;
  assign vertex_high_o = vhigh_q;
  assign status_o      = status_q;

`ifndef ASSERT_OFF
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted request missing from first stage");

  a_collision_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (vertex_low_o == '0 && vertex_high_o == '0))
    else $error("collision result carries non-zero vertices");

  a_no_false_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |-> (vertex_low_o != vertex_high_o))
    else $error("equal vertices without collision flag");

  a_stall_holds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i && vld_q[NumPipe-1]) |=> vld_q[NumPipe-1])
    else $error("last stage dropped a request during stall");
`endif

endmodule

// ===== tb/sv/seeded_dual_key_hash_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seeded_dual_key_hash_test
// Streams keys through the seeded dual key hash under every hash mode and a
// range of seed settings. Each accepted request is hashed by a local
// predictor, and every result is compared field by field against it. Both
// channels stall at random, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module seeded_dual_key_hash_test;
  import sdkh_pkg::*;

  localparam logic [31:0]          Crc32cPoly    = 32'h82F6_3B78;
  localparam int unsigned          ShiftKeyA     = 15;
  localparam int unsigned          ShiftKeyB     = 7;
  localparam int unsigned          ShiftKeyC     = 11;
  localparam int unsigned          ShiftKeyD     = 20;
  localparam logic [CfgIdxWidth-1:0] SpareIdxFirst = 3'd5;
  localparam logic [CfgIdxWidth-1:0] SpareIdxLast  = 3'd7;
  localparam int unsigned          RandPhases    = 10;
  localparam int unsigned          PhaseKeys     = 100;
  localparam int unsigned          LongHold      = 60;
  localparam int unsigned          DrainCycles   = 12;
  localparam int unsigned          WatchdogLimit = 2000;

  typedef struct {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        clash;
  } vertex_pair_t;

  class hash_scoreboard;
    hash_mode_e   mode;
    logic [31:0]  seed_one, seed_two, seed_three, seed_four;
    vertex_pair_t expected_vertices[$];
    int unsigned  mismatches;

    function new();
      mode       = ModeCrcRot;
      seed_one   = '0;
      seed_two   = '0;
      seed_three = '0;
      seed_four  = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] data);
      case (idx)
        RegHashMode: begin
          mode = hash_mode_e'(data[1:0]);
        end
        RegSeedOne: begin
          seed_one = data;
        end
        RegSeedTwo: begin
          seed_two = data;
        end
        RegSeedThree: begin
          seed_three = data;
        end
        RegSeedFour: begin
          seed_four = data;
        end
        default: begin
        end
      endcase
    endfunction

    function logic [31:0] rol(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function logic [31:0] ror(logic [31:0] v, int unsigned n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function logic [31:0] crc32c_word(logic [31:0] c, logic [31:0] d);
      logic [31:0] r;
      r = c ^ d;
      for (int i = 0; i < 32; i++) begin
        r = r[0] ? ((r >> 1) ^ Crc32cPoly) : (r >> 1);
      end
      return r;
    endfunction

    function vertex_pair_t hash_vertices(logic [31:0] key);
      logic [31:0]  v1, v2;
      vertex_pair_t r;
      case (mode)
        ModeCrcRot: begin
          v1 = crc32c_word(seed_one, key);
          v2 = crc32c_word(crc32c_word(seed_two, rol(key, ShiftKeyA)), seed_three ^ key);
        end
        ModeRotXor: begin
          v1 = rol(key ^ seed_one, ShiftKeyA) ^ ror(key - seed_three, ShiftKeyC);
          v2 = rol(key + seed_two, ShiftKeyB) ^ ror(key ^ seed_four, ShiftKeyD);
        end
        ModeAddXor: begin
          v1 = key + seed_one;
          v2 = v1 ^ (key - seed_two) ^ seed_three;
        end
        default: begin
          v1 = key ^ seed_one;
          v2 = key ^ seed_two;
        end
      endcase
      if (v1 == v2) begin
        r = '{32'd0, 32'd0, 1'b1};
      end else begin
        r = '{v1, v2, 1'b0};
      end
      return r;
    endfunction

    function void note_key(logic [31:0] key);
      expected_vertices.push_back(hash_vertices(key));
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void check_result(logic [31:0] lo, logic [31:0] hi, logic clash);
      vertex_pair_t want;
      if (expected_vertices.size() == 0) begin
        report($sformatf("result %h %h %b with no request outstanding", lo, hi, clash));
        return;
      end
      want = expected_vertices.pop_front();
      if (lo !== want.lo) report($sformatf("vertex_low %h, want %h", lo, want.lo));
      if (hi !== want.hi) report($sformatf("vertex_high %h, want %h", hi, want.hi));
      if (clash !== want.clash) report($sformatf("status %b, want %b", clash, want.clash));
    endfunction

    function int unsigned pending_count();
      return expected_vertices.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [KeyWidth-1:0]     key_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [KeyWidth-1:0]     vertex_low_o;
  logic [KeyWidth-1:0]     vertex_high_o;
  logic                    status_o;

  hash_scoreboard sb;
  bit             calm;
  bit             long_hold_req;
  int unsigned    idle_cycles;

  seeded_dual_key_hash dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vertex_low_o  (vertex_low_o),
    .vertex_high_o (vertex_high_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(vertex_low_o, vertex_high_o, status_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_settings(logic [31:0] mode_word, logic [31:0] s1, logic [31:0] s2,
                               logic [31:0] s3, logic [31:0] s4,
                               logic [CfgIdxWidth-1:0] spare_idx, logic [31:0] spare_data);
    write_reg(spare_idx, spare_data);
    write_reg(RegHashMode, mode_word);
    write_reg(RegSeedOne, s1);
    write_reg(RegSeedTwo, s2);
    write_reg(RegSeedThree, s3);
    write_reg(RegSeedFour, s4);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_key(logic [31:0] key);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_key(key);
  endtask

  // hold off new requests until every outstanding result is back
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] corner_key(int unsigned i);
    case (i)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'hAAAA_AAAA;
      default: return 32'h5555_5555;
    endcase
  endfunction

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return ~(32'd1 << $urandom_range(0, 31));
      4:       return (sb.mode == ModeAddXor) ? sb.seed_two + sb.seed_three : $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_phase(int unsigned phase);
    logic [31:0] seeds[4];
    logic [31:0] mode_word;
    mode_word = $urandom;
    mode_word[1:0] = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
    for (int i = 0; i < 4; i++) begin
      seeds[i] = (phase == 0) ? 32'h0 : (phase == 1) ? 32'hFFFF_FFFF : pick_seed();
    end
    if ($urandom_range(0, 3) == 0) seeds[1] = seeds[0];
    calm = (phase >= RandPhases - 2);
    load_settings(mode_word, seeds[0], seeds[1], seeds[2], seeds[3],
                  3'($urandom_range(SpareIdxFirst, SpareIdxLast)), $urandom);
    if (phase == 2) long_hold_req = 1'b1;
    for (int n = 0; n < PhaseKeys; n++) begin
      if (phase == 3 && n == PhaseKeys / 2) settle_block();
      send_key(pick_key());
    end
    settle_block();
  endtask

  initial begin
    sb            = new();
    calm          = 1'b0;
    long_hold_req = 1'b0;
    idle_cycles   = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    key_i         <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: a zero key collides
    for (int i = 0; i < 6; i++) send_key(corner_key(i));
    settle_block();

    load_settings(32'hFFFF_FFFC | 32'(ModeRotXor), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, SpareIdxFirst, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_key(corner_key(i));
    settle_block();

    load_settings(32'(ModeAddXor), 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                  32'h0000_0000, SpareIdxLast, 32'h0000_0001);
    for (int i = 0; i < 6; i++) send_key(corner_key(i));
    send_key(sb.seed_two + sb.seed_three);
    settle_block();

    // equal seeds make every plain xor request collide
    load_settings(32'(ModePlainXor), 32'h3C3C_A5A5, 32'h3C3C_A5A5, 32'hFFFF_FFFF,
                  32'h8000_0001, 3'd6, 32'h5A5A_5A5A);
    for (int i = 0; i < 6; i++) send_key(corner_key(i));
    settle_block();

    for (int p = 0; p < RandPhases; p++) run_random_phase(p);

    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
